// ===== src/idea_pkg.sv =====
// Shared types and constants for the IDEA CBC block cipher.
package idea_pkg;

    localparam int ROUND_COUNT = 8;
    localparam int SCHED_LEN   = 6 * ROUND_COUNT + 4;
    localparam int ROUND_W     = $clog2(ROUND_COUNT);

    localparam logic [1:0] REG_KEY_HIGH     = 2'd0;
    localparam logic [1:0] REG_KEY_LOW      = 2'd1;
    localparam logic [1:0] REG_IV_VALUE     = 2'd2;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd3;

    typedef struct packed {
        logic capture;
        logic kinit;
        logic kwrite;
        logic kwr_inv;
        logic inv_start;
        logic inv_step;
        logic blk_init;
        logic step_a;
        logic step_b;
        logic step_c;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_inv;
        logic inv_last;
        logic j_last;
        logic key_cfg_wr;
    } t_sts;

endpackage

// ===== src/idea_dp.sv =====
// Datapath: configuration registers, subkey memory, schedule builder and round logic.
module idea_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  idea_pkg::t_cmd   i_cmd,
    output idea_pkg::t_sts   o_sts,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data,
    input  logic [63:0]      i_block_in,
    input  logic             i_first_block,
    output logic [63:0]      o_block_out
);
    import idea_pkg::*;

    function automatic logic [15:0] f_mul(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        logic [15:0] lo;
        logic [15:0] hi;
        p  = 32'(a) * 32'(b);
        lo = p[15:0];
        hi = p[31:16];
        if (a == 16'd0) begin
            f_mul = 16'd1 - b;
        end else if (b == 16'd0) begin
            f_mul = 16'd1 - a;
        end else begin
            f_mul = lo - hi + {15'd0, (lo < hi)};
        end
    endfunction

    logic [63:0]  r_key_hi, r_key_lo, r_iv;
    logic         r_dec;
    logic [63:0]  r_in_blk;
    logic         r_in_first;
    logic [63:0]  r_chain, r_cv, r_out;
    logic [15:0]  r_mem [0:SCHED_LEN-1];
    logic [127:0] r_kreg;
    logic [5:0]   r_j, r_p0;
    logic [2:0]   r_q;
    logic [15:0]  r_acc, r_invx;
    logic [4:0]   r_icnt;
    logic [5:0]   r_f;
    logic [1:0]   r_pair, r_cap_slot;
    logic         r_fetch_act, r_cap_v;
    logic [15:0]  r_rd0, r_rd1;
    logic [15:0]  r_kb [0:5];
    logic [15:0]  r_x1, r_x2, r_x3, r_x4, r_t2;

    logic [15:0]  w, wval, mul_a, mul_b, mul_ya, mul_yb, mres, t2n;
    logic [15:0]  y1, y2, y3, y4;
    logic [5:0]   wdest;
    logic         op_inv, op_neg, body, last_r;
    logic [127:0] kinit_val;
    logic [63:0]  ceff, din, res;

    assign w      = r_kreg[(3'd7 - r_j[2:0]) * 16 +: 16];
    assign body   = (r_j >= 6'd4);
    assign last_r = (r_p0 == 6'd6);

    always_comb begin
        op_inv = 1'b0;
        op_neg = 1'b0;
        wdest  = r_j;
        if (!body) begin
            wdest  = 6'd48 + {4'd0, r_j[1:0]};
            op_inv = (r_j[1:0] == 2'd0) || (r_j[1:0] == 2'd3);
            op_neg = !op_inv;
        end else begin
            case (r_q)
                3'd0: wdest = r_p0 - 6'd2;
                3'd1: wdest = r_p0 - 6'd1;
                3'd2: begin wdest = r_p0 - 6'd6; op_inv = 1'b1; end
                3'd3: begin wdest = last_r ? r_p0 - 6'd5 : r_p0 - 6'd4; op_neg = 1'b1; end
                3'd4: begin wdest = last_r ? r_p0 - 6'd4 : r_p0 - 6'd5; op_neg = 1'b1; end
                3'd5: begin wdest = r_p0 - 6'd3; op_inv = 1'b1; end
                default: wdest = r_p0;
            endcase
        end
        if (!r_dec) begin
            wdest = r_j;
        end
        if (i_cmd.kwr_inv) begin
            wval = r_acc;
        end else if (r_dec && op_neg) begin
            wval = 16'd0 - w;
        end else begin
            wval = w;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            kinit_val[(7 - i) * 16 +: 16] = {r_key_hi[63 - 8 * i -: 8], r_key_lo[63 - 8 * i -: 8]};
        end
    end

    always_comb begin
        mul_a = r_x1;
        mul_b = r_kb[0];
        if (i_cmd.inv_step) begin
            mul_a = r_acc;
            mul_b = r_icnt[0] ? r_invx : r_acc;
        end else if (i_cmd.step_b) begin
            mul_a = r_x1 ^ r_x3;
            mul_b = r_kb[4];
        end else if (i_cmd.step_c) begin
            mul_a = r_t2 + (r_x2 ^ r_x4);
            mul_b = r_kb[5];
        end
    end

    assign mul_ya = f_mul(mul_a, mul_b);
    assign mul_yb = f_mul(r_x4, r_kb[3]);
    assign mres   = mul_ya;
    assign t2n    = mres + r_t2;

    assign y1  = mul_ya;
    assign y3  = r_x3 + r_kb[1];
    assign y2  = r_x2 + r_kb[2];
    assign y4  = mul_yb;
    assign res = {y4[15:8], y2[15:8], y3[15:8], y1[15:8], y4[7:0], y2[7:0], y3[7:0], y1[7:0]}
                 ^ (r_dec ? r_cv : 64'd0);

    assign ceff = r_in_first ? r_iv : r_chain;
    assign din  = r_dec ? r_in_blk : (r_in_blk ^ ceff);

    assign o_sts.need_inv   = r_dec && op_inv && (w > 16'd1);
    assign o_sts.inv_last   = (r_icnt == 5'd29);
    assign o_sts.j_last     = (r_j == 6'(SCHED_LEN - 1));
    assign o_sts.key_cfg_wr = i_cfg_valid && (i_cfg_index != REG_IV_VALUE);
    assign o_block_out      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi    <= 64'd0;
            r_key_lo    <= 64'd0;
            r_iv        <= 64'd0;
            r_dec       <= 1'b0;
            r_chain     <= 64'd0;
            r_fetch_act <= 1'b0;
            r_cap_v     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_KEY_HIGH:     r_key_hi <= i_cfg_data;
                    REG_KEY_LOW:      r_key_lo <= i_cfg_data;
                    REG_IV_VALUE:     r_iv     <= i_cfg_data;
                    REG_DECRYPT_MODE: r_dec    <= i_cfg_data[0];
                    default:          r_dec    <= r_dec;
                endcase
            end
            if (i_cmd.blk_init && r_dec) begin
                r_chain <= r_in_blk;
            end
            if (i_cmd.out_load && !r_dec) begin
                r_chain <= res;
            end
            r_cap_v <= r_fetch_act;
            if (i_cmd.blk_init) begin
                r_fetch_act <= 1'b1;
            end else if (r_fetch_act && (r_f == 6'(SCHED_LEN - 2))) begin
                r_fetch_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_blk   <= i_block_in;
            r_in_first <= i_first_block;
        end
        if (i_cmd.kinit) begin
            r_kreg <= kinit_val;
            r_j    <= 6'd0;
            r_q    <= 3'd0;
            r_p0   <= 6'd48;
        end
        if (i_cmd.kwrite) begin
            r_mem[wdest] <= wval;
            r_j <= r_j + 6'd1;
            if (r_j[2:0] == 3'd7) begin
                r_kreg <= {r_kreg[102:0], r_kreg[127:103]};
            end
            if (body) begin
                r_q <= (r_q == 3'd5) ? 3'd0 : r_q + 3'd1;
                if (r_q == 3'd5) begin
                    r_p0 <= r_p0 - 6'd6;
                end
            end
        end
        if (i_cmd.inv_start) begin
            r_acc  <= w;
            r_invx <= w;
            r_icnt <= 5'd0;
        end
        if (i_cmd.inv_step) begin
            r_acc  <= mul_ya;
            r_icnt <= r_icnt + 5'd1;
        end
        if (i_cmd.blk_init) begin
            r_f    <= 6'd0;
            r_pair <= 2'd0;
            r_cv   <= ceff;
            r_x1   <= {din[39:32], din[7:0]};
            r_x2   <= {din[47:40], din[15:8]};
            r_x3   <= {din[55:48], din[23:16]};
            r_x4   <= {din[63:56], din[31:24]};
        end
        if (r_fetch_act) begin
            r_rd0      <= r_mem[r_f];
            r_rd1      <= r_mem[r_f + 6'd1];
            r_cap_slot <= r_pair;
            r_f        <= r_f + 6'd2;
            r_pair     <= (r_pair == 2'd2) ? 2'd0 : r_pair + 2'd1;
        end
        if (r_cap_v) begin
            r_kb[{r_cap_slot, 1'b0}] <= r_rd0;
            r_kb[{r_cap_slot, 1'b1}] <= r_rd1;
        end
        if (i_cmd.step_a) begin
            r_x1 <= mul_ya;
            r_x4 <= mul_yb;
            r_x2 <= r_x2 + r_kb[1];
            r_x3 <= r_x3 + r_kb[2];
        end
        if (i_cmd.step_b) begin
            r_t2 <= mres;
        end
        if (i_cmd.step_c) begin
            r_x1 <= r_x1 ^ mres;
            r_x4 <= r_x4 ^ t2n;
            r_x2 <= r_x3 ^ mres;
            r_x3 <= t2n ^ r_x2;
        end
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

endmodule

// ===== src/idea_ctrl.sv =====
// Controller: sequences subkey schedule building, block rounds and result hand-off.
module idea_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  idea_pkg::t_sts   i_sts,
    output idea_pkg::t_cmd   o_cmd
);
    import idea_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_KSTEP = 9'b000000010,
        S_KINV  = 9'b000000100,
        S_KWR   = 9'b000001000,
        S_LOAD  = 9'b000010000,
        S_RA    = 9'b000100000,
        S_RB    = 9'b001000000,
        S_RC    = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_cnt, n_cnt;
    logic [ROUND_W-1:0]   r_round, n_round;
    logic                 r_sched, n_sched;
    logic                 r_out_valid, n_out_valid;
    logic                 in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_round     = r_round;
        n_sched     = r_sched;
        o_cmd       = '0;
        o_cmd.capture = in_acc;
        if (i_sts.key_cfg_wr) begin
            n_sched = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cnt = 2'd0;
                    if (!r_sched) begin
                        o_cmd.kinit = 1'b1;
                        n_state     = S_KSTEP;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_KSTEP: begin
                if (i_sts.need_inv) begin
                    o_cmd.inv_start = 1'b1;
                    n_state         = S_KINV;
                end else begin
                    o_cmd.kwrite = 1'b1;
                    if (i_sts.j_last) begin
                        n_sched = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_KINV: begin
                o_cmd.inv_step = 1'b1;
                if (i_sts.inv_last) begin
                    n_state = S_KWR;
                end
            end
            S_KWR: begin
                o_cmd.kwrite  = 1'b1;
                o_cmd.kwr_inv = 1'b1;
                if (i_sts.j_last) begin
                    n_sched = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_KSTEP;
                end
            end
            S_LOAD: begin
                o_cmd.blk_init = (r_cnt == 2'd0);
                n_cnt          = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_round = '0;
                    n_state = S_RA;
                end
            end
            S_RA: begin
                o_cmd.step_a = 1'b1;
                n_state      = S_RB;
            end
            S_RB: begin
                o_cmd.step_b = 1'b1;
                n_state      = S_RC;
            end
            S_RC: begin
                o_cmd.step_c = 1'b1;
                if (r_round == ROUND_W'(ROUND_COUNT - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_round = r_round + 1'b1;
                    n_state = S_RA;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_round     <= '0;
            r_sched     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_round     <= n_round;
            r_sched     <= n_sched;
            r_out_valid <= n_out_valid;
        end
    end

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken word");

    a_stale_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_sched) |=> (r_state == S_KSTEP))
        else $error("stale schedule not rebuilt");

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RC && r_round == ROUND_W'(ROUND_COUNT - 1)) |=> (r_state == S_OUT))
        else $error("round count overrun");

endmodule

// ===== src/idea_cbc_block_cipher_top.sv =====
// Top level of the IDEA CBC block cipher.
// Input words arrive on the s_axis channel: tdata carries the 64-bit block, tuser the
// first-block flag that reloads the chaining value from the IV register. Results leave
// on the m_axis channel, one 64-bit word per input word, in order.
// Registers are written over the cfg channel (0 key high, 1 key low, 2 IV, 3 decrypt
// mode), which is always ready; the user must make writes only while the block is idle,
// as the block itself does not enforce this. One word is worked on at a time. With a
// valid schedule a word goes from acceptance through set-up, three steps per round for
// eight rounds on two shared 16-bit multipliers fed from a two-port subkey memory, and
// the output transform, until its result is loaded into the output register.
// A new word is accepted the cycle after the result is loaded, and none before then.
// After a write to the key or mode, the next word first rebuilds the 52 subkeys; for
// decryption, up to 18 inverses are each found by 30 modular multiplications.
// Reset clears the registers, the chaining value and the output valid, and marks the
// schedule stale. A stalled receiver holds the result; the block finishes the next
// word and then waits until the output register is free.
module idea_cbc_block_cipher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // block_in
    input  logic [0:0]  s_axis_tuser,   // first_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // block_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import idea_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    idea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    idea_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_block_in    (s_axis_tdata),
        .i_first_block (s_axis_tuser[0]),
        .o_block_out   (m_axis_tdata)
    );

endmodule
